// ----- design/rsof_pkg.sv -----
`timescale 1ns / 1ps

package rsof_pkg;

	// Encoder direction of each wheel: +1 counts forward, -1 reversed, 0 ignored.
	localparam int LEFT_SIGN  = 1;
	localparam int RIGHT_SIGN = 1;

	localparam int ODO_W    = 48;
	localparam int FRAC_W   = 16;
	localparam int SCALE_W  = 24;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam logic [ODO_W-1:0] ODO_MAX = '1;

	// Command codes carried on the input tuser.
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	// Run state codes reported with every result word.
	typedef enum logic [2:0] {
		RS_IDLE     = 3'd0,
		RS_RUNNING  = 3'd1,
		RS_COMPLETE = 3'd2,
		RS_CHASSIS  = 3'd3,
		RS_OFFLINE  = 3'd4,
		RS_TIMEOUT  = 3'd5,
		RS_LOST     = 3'd6,
		RS_USER     = 3'd7
	} run_state_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DISTANCE_SCALE = 3'd0,
		REG_APPROACH_DIST  = 3'd1,
		REG_ARM_DIST       = 3'd2,
		REG_POST_MARKER    = 3'd3,
		REG_LAP_TIMEOUT    = 3'd4,
		REG_OFFLINE_TMO    = 3'd5,
		REG_LINE_LOSS_TMO  = 3'd6,
		REG_MARKER_DEB     = 3'd7
	} reg_idx_t;

	// Input word layout, lowest bit at the bottom of the list.
	typedef struct packed {
		logic [2:0]  pad;
		logic        marker_seen;
		logic        track_lost;
		logic        sensor_online;
		logic        chassis_following;
		logic        chassis_disabled;
		logic [31:0] right_total;
		logic [31:0] left_total;
		logic [31:0] now_ms;
	} in_word_t;

	// Result word layout, lowest bit at the bottom of the list.
	typedef struct packed {
		logic [5:0]  pad;
		logic        follow_enable;
		logic        speed_select;
		logic        stop_motor;
		logic        braking;
		logic        finish_ready;
		logic        approach_on;
		logic [31:0] brake_distance_um;
		logic [31:0] distance_um;
		logic [31:0] run_time_ms;
		logic        start_accepted;
		run_state_t  run_state;
	} out_word_t;

	// Progress and debounce flags of a run.
	typedef struct packed {
		logic approach;
		logic armed;
		logic braking;
		logic marker;
		logic lost;
		logic offline;
	} flags_t;

endpackage

// ----- design/run_supervisor_odometry_fsm_unit.sv -----
`timescale 1ns / 1ps
// An accepted word is held in the input register and its result word in the result register.
// Throughput: one word per cycle while the output is not stalled; the supervisor state updates
// in the same pass that fills the result register, so the next word sees it at once.
// Reset (arst_n low, asynchronous): run idle, odometry and timers zero, registers
// at their defaults; no clearing pass is needed.
module run_supervisor_odometry_fsm_unit
	import rsof_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// now_ms[31:0], left_total[63:32], right_total[95:64], chassis_disabled[96],
	// chassis_following[97], sensor_online[98], track_lost[99], marker_seen[100], zero pad
	input  logic [103:0]         s_tdata,
	// command[1:0]
	input  logic [1:0]           s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// run_state[2:0], start_accepted[3], run_time_ms[35:4], distance_um[67:36],
	// brake_distance_um[99:68], approach_on[100], finish_ready[101], braking[102],
	// stop_motor[103], speed_select[104], follow_enable[105], zero pad
	output logic [111:0]         m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [SCALE_W-1:0] distance_scale_q;
	logic [23:0]        approach_distance_q;
	logic [23:0]        arm_distance_q;
	logic [23:0]        post_marker_distance_q;
	logic [31:0]        lap_timeout_q;
	logic [15:0]        offline_timeout_q;
	logic [15:0]        line_loss_timeout_q;
	logic [15:0]        marker_debounce_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			distance_scale_q       <= 24'd65536;
			approach_distance_q    <= '0;
			arm_distance_q         <= '0;
			post_marker_distance_q <= 24'd230000;
			lap_timeout_q          <= 32'd60000;
			offline_timeout_q      <= 16'd500;
			line_loss_timeout_q    <= 16'd500;
			marker_debounce_q      <= 16'd20;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DISTANCE_SCALE: distance_scale_q       <= cfg_data[SCALE_W-1:0];
				REG_APPROACH_DIST:  approach_distance_q    <= cfg_data[23:0];
				REG_ARM_DIST:       arm_distance_q         <= cfg_data[23:0];
				REG_POST_MARKER:    post_marker_distance_q <= cfg_data[23:0];
				REG_LAP_TIMEOUT:    lap_timeout_q          <= cfg_data[31:0];
				REG_OFFLINE_TMO:    offline_timeout_q      <= cfg_data[15:0];
				REG_LINE_LOSS_TMO:  line_loss_timeout_q    <= cfg_data[15:0];
				REG_MARKER_DEB:     marker_debounce_q      <= cfg_data[15:0];
			endcase
		end
	end

	// Handshake: the input register moves on whenever the result register is free
	// or being emptied.
	logic      valid_s1;
	in_word_t  word_s1;
	cmd_t      cmd_s1;
	logic      advance;
	logic      out_valid_q;
	out_word_t out_q;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			word_s1 <= in_word_t'(s_tdata);
			cmd_s1  <= cmd_t'(s_tuser);
		end
	end

	// Supervisor state.
	run_state_t       phase_q;
	logic [31:0]      start_time_q;
	logic [31:0]      elapsed_q;
	logic [31:0]      last_left_q;
	logic [31:0]      last_right_q;
	logic [ODO_W-1:0] odometer_q;
	logic [ODO_W-1:0] marker_odometer_q;
	logic [ODO_W-1:0] brake_odometer_q;
	logic [31:0]      marker_since_q;
	logic [31:0]      lost_since_q;
	logic [31:0]      offline_since_q;
	flags_t           flags_q;

	// Odometry: signed encoder deltas, forward sum, scaled and saturated.
	logic signed [31:0]      dl;
	logic signed [31:0]      dr;
	logic signed [33:0]      term_l;
	logic signed [33:0]      term_r;
	logic signed [33:0]      sum_s;
	logic                    forward;
	logic [56:0]             product;
	logic [ODO_W:0]          odo_sum;
	logic [ODO_W-1:0]        odo_adv;

	always_comb begin
		dl = signed'(word_s1.left_total - last_left_q);
		dr = signed'(word_s1.right_total - last_right_q);
		term_l = (LEFT_SIGN > 0) ? 34'(dl) : ((LEFT_SIGN < 0) ? -34'(dl) : '0);
		term_r = (RIGHT_SIGN > 0) ? 34'(dr) : ((RIGHT_SIGN < 0) ? -34'(dr) : '0);
		sum_s = term_l + term_r;
		forward = !sum_s[33] && (sum_s != '0);
		product = 57'(sum_s[32:0]) * 57'(distance_scale_q);
		odo_sum = (ODO_W+1)'(odometer_q) + (ODO_W+1)'(product[56:1]);
		if (!forward) begin
			odo_adv = odometer_q;
		end else if (product[56:ODO_W+1] != '0 || odo_sum[ODO_W]) begin
			odo_adv = ODO_MAX;
		end else begin
			odo_adv = odo_sum[ODO_W-1:0];
		end
	end

	// Next state and result for the word in the input register.
	run_state_t       phase_n;
	logic [31:0]      start_time_n;
	logic [31:0]      elapsed_n;
	logic [31:0]      last_left_n;
	logic [31:0]      last_right_n;
	logic [ODO_W-1:0] odometer_n;
	logic [ODO_W-1:0] marker_odometer_n;
	logic [ODO_W-1:0] brake_odometer_n;
	logic [31:0]      marker_since_n;
	logic [31:0]      lost_since_n;
	logic [31:0]      offline_since_n;
	flags_t           flags_n;
	logic             accepted;
	logic             stop;
	logic             follow;
	logic             ended;
	run_state_t       end_code;
	out_word_t        result;

	always_comb begin
		phase_n           = phase_q;
		start_time_n      = start_time_q;
		elapsed_n         = elapsed_q;
		last_left_n       = last_left_q;
		last_right_n      = last_right_q;
		odometer_n        = odometer_q;
		marker_odometer_n = marker_odometer_q;
		brake_odometer_n  = brake_odometer_q;
		marker_since_n    = marker_since_q;
		lost_since_n      = lost_since_q;
		offline_since_n   = offline_since_q;
		flags_n           = flags_q;
		accepted          = 1'b0;
		follow            = 1'b0;
		ended             = 1'b0;
		end_code          = RS_COMPLETE;

		case (cmd_s1)
			CMD_START: begin
				if (word_s1.chassis_disabled) begin
					phase_n           = RS_RUNNING;
					flags_n           = '0;
					elapsed_n         = '0;
					odometer_n        = '0;
					brake_odometer_n  = '0;
					marker_odometer_n = '0;
					start_time_n      = word_s1.now_ms;
					last_left_n       = word_s1.left_total;
					last_right_n      = word_s1.right_total;
					accepted          = 1'b1;
					follow            = 1'b1;
				end
			end
			CMD_TICK: begin
				if (phase_q == RS_RUNNING) begin
					elapsed_n    = word_s1.now_ms - start_time_q;
					last_left_n  = word_s1.left_total;
					last_right_n = word_s1.right_total;
					odometer_n   = odo_adv;
					// Checks in priority order; the first ending wins.
					if (!word_s1.chassis_following) begin
						ended    = 1'b1;
						end_code = RS_CHASSIS;
					end else if (!word_s1.sensor_online && flags_q.offline &&
							(word_s1.now_ms - offline_since_q) >= 32'(offline_timeout_q)) begin
						ended    = 1'b1;
						end_code = RS_OFFLINE;
					end else begin
						if (!word_s1.sensor_online) begin
							if (!flags_q.offline) begin
								flags_n.offline = 1'b1;
								offline_since_n = word_s1.now_ms;
							end
						end else begin
							flags_n.offline = 1'b0;
						end
						if (elapsed_n >= lap_timeout_q) begin
							ended    = 1'b1;
							end_code = RS_TIMEOUT;
						end else if (word_s1.track_lost && flags_q.lost &&
								(word_s1.now_ms - lost_since_q) >= 32'(line_loss_timeout_q)) begin
							ended    = 1'b1;
							end_code = RS_LOST;
						end else begin
							if (word_s1.track_lost) begin
								if (!flags_q.lost) begin
									flags_n.lost = 1'b1;
									lost_since_n = word_s1.now_ms;
								end
							end else begin
								flags_n.lost = 1'b0;
							end
							if (odo_adv >= {approach_distance_q, {FRAC_W{1'b0}}}) begin
								flags_n.approach = 1'b1;
							end
							if (odo_adv >= {arm_distance_q, {FRAC_W{1'b0}}}) begin
								flags_n.armed = 1'b1;
							end
							if (flags_q.braking) begin
								brake_odometer_n = odo_adv - marker_odometer_q;
								if (brake_odometer_n >= {post_marker_distance_q, {FRAC_W{1'b0}}}) begin
									ended    = 1'b1;
									end_code = RS_COMPLETE;
								end
							end else if (flags_n.armed && word_s1.marker_seen) begin
								if (!flags_q.marker) begin
									flags_n.marker    = 1'b1;
									marker_since_n    = word_s1.now_ms;
									marker_odometer_n = odo_adv;
								end else if ((word_s1.now_ms - marker_since_q) >=
										32'(marker_debounce_q)) begin
									flags_n.braking  = 1'b1;
									flags_n.approach = 1'b1;
									brake_odometer_n = odo_adv - marker_odometer_q;
								end
							end else begin
								flags_n.marker = 1'b0;
							end
						end
					end
				end
			end
			CMD_STOP: begin
				if (phase_q == RS_RUNNING) begin
					ended    = 1'b1;
					end_code = RS_USER;
				end
			end
			default: begin
			end
		endcase

		// Any ending freezes the time and drops the debounce trackers.
		if (ended) begin
			elapsed_n      = word_s1.now_ms - start_time_q;
			phase_n        = end_code;
			flags_n.marker = 1'b0;
			flags_n.lost   = 1'b0;
			flags_n.offline = 1'b0;
		end
		stop = ended;

		result                   = '0;
		result.run_state         = phase_n;
		result.start_accepted    = accepted;
		result.run_time_ms       = elapsed_n;
		result.distance_um       = odometer_n[ODO_W-1:FRAC_W];
		result.brake_distance_um = brake_odometer_n[ODO_W-1:FRAC_W];
		result.approach_on       = flags_n.approach;
		result.finish_ready      = flags_n.armed;
		result.braking           = flags_n.braking;
		result.stop_motor        = stop;
		result.speed_select      = (phase_n == RS_RUNNING) && flags_n.approach;
		result.follow_enable     = follow;
	end

	// State commit, together with the result register load.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q           <= RS_IDLE;
			start_time_q      <= '0;
			elapsed_q         <= '0;
			last_left_q       <= '0;
			last_right_q      <= '0;
			odometer_q        <= '0;
			marker_odometer_q <= '0;
			brake_odometer_q  <= '0;
			marker_since_q    <= '0;
			lost_since_q      <= '0;
			offline_since_q   <= '0;
			flags_q           <= '0;
			out_valid_q       <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q           <= phase_n;
				start_time_q      <= start_time_n;
				elapsed_q         <= elapsed_n;
				last_left_q       <= last_left_n;
				last_right_q      <= last_right_n;
				odometer_q        <= odometer_n;
				marker_odometer_q <= marker_odometer_n;
				brake_odometer_q  <= brake_odometer_n;
				marker_since_q    <= marker_since_n;
				lost_since_q      <= lost_since_n;
				offline_since_q   <= offline_since_n;
				flags_q           <= flags_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= result;
		end
	end

	// A stop pulse always reports a finished run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.stop_motor |->
			out_q.run_state != RS_RUNNING && out_q.run_state != RS_IDLE)
		else $error("stop pulse without a finished run state");

	// A follow pulse comes only with an accepted start and a running state.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.follow_enable |->
			out_q.start_accepted && out_q.run_state == RS_RUNNING)
		else $error("follow pulse without an accepted start");

	// Approach speed is requested only while running in the approach phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.speed_select |->
			out_q.approach_on && out_q.run_state == RS_RUNNING)
		else $error("approach speed outside the approach phase");

	// The input side stalls only when both stages hold a word that is not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled with a free stage");

	// The state held in the result register matches the committed run state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance && valid_s1) |-> out_q.run_state == phase_q)
		else $error("result run state differs from the committed state");

endmodule

// ----- tb/run_supervisor_odometry_fsm_unit_tb.sv -----
`timescale 1ns / 1ps

module run_supervisor_odometry_fsm_unit_tb;
	import rsof_pkg::*;

	// Command code that the block must ignore.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0] cmd;
		in_word_t   w;
	} cmd_item_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [103:0]         s_tdata = '0;
	logic [1:0]           s_tuser = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [111:0]         m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	run_supervisor_odometry_fsm_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Command words waiting to be sent and status words still owed by the block.
	cmd_item_t pending_cmds[$];
	out_word_t expected_words[$];
	int items_queued = 0;
	int items_taken = 0;
	int words_seen = 0;
	int errors = 0;

	// Our own copy of the supervisor state and its registers.
	run_state_t  run_ph;
	flags_t      fl;
	logic [31:0] t_start, t_elapsed, enc_left, enc_right;
	logic [31:0] t_marker, t_lost, t_offline;
	logic [47:0] odo, odo_at_marker, odo_brake;
	logic        motor_stop_due;
	logic [23:0] cfg_scale, cfg_approach, cfg_arm, cfg_post;
	logic [31:0] cfg_lap;
	logic [15:0] cfg_offline, cfg_lost, cfg_debounce;

	// Stimulus generator state: time base and encoder totals carried across runs.
	logic [31:0] gen_now, gen_l, gen_r;

	// Sender and receiver pacing.
	int tx_wait = 0;
	int tx_calm = 0;
	int rx_wait = 0;
	int rx_calm = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Ends the run the way the block does: freeze the time and clear the trackers.
	task finish_run(input run_state_t code, input logic [31:0] at_ms);
		t_elapsed = at_ms - t_start;
		run_ph = code;
		fl.marker = 1'b0;
		fl.lost = 1'b0;
		fl.offline = 1'b0;
		motor_stop_due = 1'b1;
	endtask

	// Applies one command word to the supervisor copy and queues the status it yields.
	task supervise(input logic [1:0] cmd, input in_word_t w);
		out_word_t   res;
		logic [31:0] dlu, dru;
		longint      dsum;
		logic [63:0] inc;
		logic        took;
		took = 1'b0;
		motor_stop_due = 1'b0;
		case (cmd)
		CMD_START: begin
			if (w.chassis_disabled) begin
				run_ph = RS_RUNNING;
				fl = '0;
				t_elapsed = '0;
				odo = '0;
				odo_brake = '0;
				odo_at_marker = '0;
				t_start = w.now_ms;
				enc_left = w.left_total;
				enc_right = w.right_total;
				took = 1'b1;
			end
		end
		CMD_TICK: begin
			if (run_ph == RS_RUNNING) begin
				t_elapsed = w.now_ms - t_start;
				// Forward odometry from wrapped encoder deltas; backward motion adds nothing.
				dlu = w.left_total - enc_left;
				dru = w.right_total - enc_right;
				enc_left = w.left_total;
				enc_right = w.right_total;
				dsum = LEFT_SIGN * longint'($signed(dlu)) + RIGHT_SIGN * longint'($signed(dru));
				if (dsum > 0) begin
					inc = (64'(dsum) * 64'(cfg_scale)) >> 1;
					if (inc > 64'(ODO_MAX - odo))
						odo = ODO_MAX;
					else
						odo = odo + inc[47:0];
				end
				if (!w.chassis_following)
					finish_run(RS_CHASSIS, w.now_ms);
				if (run_ph == RS_RUNNING) begin
					if (!w.sensor_online) begin
						if (!fl.offline) begin
							fl.offline = 1'b1;
							t_offline = w.now_ms;
						end else if (w.now_ms - t_offline >= cfg_offline) begin
							finish_run(RS_OFFLINE, w.now_ms);
						end
					end else begin
						fl.offline = 1'b0;
					end
				end
				if (run_ph == RS_RUNNING && t_elapsed >= cfg_lap)
					finish_run(RS_TIMEOUT, w.now_ms);
				if (run_ph == RS_RUNNING) begin
					if (w.track_lost) begin
						if (!fl.lost) begin
							fl.lost = 1'b1;
							t_lost = w.now_ms;
						end else if (w.now_ms - t_lost >= cfg_lost) begin
							finish_run(RS_LOST, w.now_ms);
						end
					end else begin
						fl.lost = 1'b0;
					end
				end
				if (run_ph == RS_RUNNING) begin
					if (odo >= 48'(cfg_approach) << 16)
						fl.approach = 1'b1;
					if (odo >= 48'(cfg_arm) << 16)
						fl.armed = 1'b1;
					// Braking runs out the post-marker distance; otherwise debounce the marker.
					if (fl.braking) begin
						odo_brake = odo - odo_at_marker;
						if (odo_brake >= 48'(cfg_post) << 16)
							finish_run(RS_COMPLETE, w.now_ms);
					end else if (fl.armed && w.marker_seen) begin
						if (!fl.marker) begin
							fl.marker = 1'b1;
							t_marker = w.now_ms;
							odo_at_marker = odo;
						end else if (w.now_ms - t_marker >= cfg_debounce) begin
							fl.braking = 1'b1;
							fl.approach = 1'b1;
							odo_brake = odo - odo_at_marker;
						end
					end else begin
						fl.marker = 1'b0;
					end
				end
			end
		end
		CMD_STOP: begin
			if (run_ph == RS_RUNNING)
				finish_run(RS_USER, w.now_ms);
		end
		default: ;
		endcase
		res = '0;
		res.run_state = run_ph;
		res.start_accepted = took;
		res.run_time_ms = t_elapsed;
		res.distance_um = odo[47:16];
		res.brake_distance_um = odo_brake[47:16];
		res.approach_on = fl.approach;
		res.finish_ready = fl.armed;
		res.braking = fl.braking;
		res.stop_motor = motor_stop_due;
		res.speed_select = (run_ph == RS_RUNNING) && fl.approach;
		res.follow_enable = took;
		expected_words.push_back(res);
	endtask

	function void compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	task check_word(input out_word_t got);
		out_word_t want;
		if (expected_words.size() == 0) begin
			$error("status word with nothing expected: %h", got);
			errors++;
		end else begin
			want = expected_words.pop_front();
			compare_field("run_state", want.run_state, got.run_state);
			compare_field("start_accepted", want.start_accepted, got.start_accepted);
			compare_field("run_time_ms", want.run_time_ms, got.run_time_ms);
			compare_field("distance_um", want.distance_um, got.distance_um);
			compare_field("brake_distance_um", want.brake_distance_um, got.brake_distance_um);
			compare_field("approach_on", want.approach_on, got.approach_on);
			compare_field("finish_ready", want.finish_ready, got.finish_ready);
			compare_field("braking", want.braking, got.braking);
			compare_field("stop_motor", want.stop_motor, got.stop_motor);
			compare_field("speed_select", want.speed_select, got.speed_select);
			compare_field("follow_enable", want.follow_enable, got.follow_enable);
		end
	endtask

	// Input side: present queued command words with random gaps and predict each one taken.
	always @(posedge clk or negedge arst_n) begin : tx_side
		cmd_item_t nxt;
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				supervise(s_tuser, s_tdata);
				items_taken++;
			end
			if (s_tvalid && !s_tready) begin
				// Hold the word until the block takes it.
			end else if (tx_wait != 0) begin
				s_tvalid <= 1'b0;
				tx_wait <= tx_wait - 1;
			end else if (pending_cmds.size() != 0) begin
				nxt = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.w;
				s_tuser <= nxt.cmd;
				if (tx_calm != 0) begin
					tx_calm--;
					gap = 0;
				end else if ($urandom_range(0, 49) == 0) begin
					tx_calm = 60;
					gap = 0;
				end else begin
					gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
				end
				tx_wait <= gap;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Output side: check each status word and stall at random, with a long hold now and then.
	always @(posedge clk or negedge arst_n) begin : rx_side
		int stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_word(m_tdata);
				words_seen++;
			end
			if (rx_wait != 0) begin
				rx_wait <= rx_wait - 1;
			end else if (m_tvalid && m_tready) begin
				if (words_seen % 300 == 40) begin
					stall = 120;
				end else if (rx_calm != 0) begin
					rx_calm--;
					stall = 0;
				end else if ($urandom_range(0, 39) == 0) begin
					rx_calm = 40;
					stall = 0;
				end else begin
					stall = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 16) : 0;
				end
				if (stall != 0) begin
					m_tready <= 1'b0;
					rx_wait <= stall - 1;
				end
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task put(input logic [1:0] cmd, input logic [31:0] at_ms, input logic [31:0] l,
		input logic [31:0] r, input logic dis, input logic fol, input logic onl,
		input logic lst, input logic mark);
		cmd_item_t it;
		it.cmd = cmd;
		it.w = '0;
		it.w.now_ms = at_ms;
		it.w.left_total = l;
		it.w.right_total = r;
		it.w.chassis_disabled = dis;
		it.w.chassis_following = fol;
		it.w.sensor_online = onl;
		it.w.track_lost = lst;
		it.w.marker_seen = mark;
		pending_cmds.push_back(it);
		items_queued++;
	endtask

	// Waits until every word sent has been answered and the pipeline is empty.
	task settle();
		while (items_taken != items_queued || expected_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task write_reg(input reg_idx_t idx, input logic [31:0] val);
		case (idx)
		REG_DISTANCE_SCALE: cfg_scale = val[23:0];
		REG_APPROACH_DIST:  cfg_approach = val[23:0];
		REG_ARM_DIST:       cfg_arm = val[23:0];
		REG_POST_MARKER:    cfg_post = val[23:0];
		REG_LAP_TIMEOUT:    cfg_lap = val;
		REG_OFFLINE_TMO:    cfg_offline = val[15:0];
		REG_LINE_LOSS_TMO:  cfg_lost = val[15:0];
		REG_MARKER_DEB:     cfg_debounce = val[15:0];
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Picks distances and timeouts that a run at the given pace can actually reach.
	task random_config(input int ms_max, input int cnt_max);
		logic [63:0] per_tick, lim;
		logic [23:0] scale;
		if ($urandom_range(0, 3) == 0)
			scale = 24'($urandom);
		else
			scale = 24'($urandom_range(32'h400, 32'h40000));
		per_tick = ((64'(cnt_max) / 2) * scale) >> 16;
		lim = per_tick * 12;
		if (lim > 64'hFF_FFFF)
			lim = 64'hFF_FFFF;
		write_reg(REG_DISTANCE_SCALE, 32'(scale));
		write_reg(REG_APPROACH_DIST, $urandom_range(0, 32'(lim)));
		write_reg(REG_ARM_DIST, $urandom_range(0, 32'(lim)));
		write_reg(REG_POST_MARKER, $urandom_range(0, 32'(lim)));
		write_reg(REG_LAP_TIMEOUT, $urandom_range(ms_max * 10, ms_max * 80));
		write_reg(REG_OFFLINE_TMO, $urandom_range(0, ms_max * 4));
		write_reg(REG_LINE_LOSS_TMO, $urandom_range(0, ms_max * 4));
		write_reg(REG_MARKER_DEB, $urandom_range(0, ms_max * 3));
	endtask

	// Encoder step of one wheel: mostly forward, sometimes backward, rarely a wild jump.
	function automatic logic [31:0] wheel_step(input int cnt_max);
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return $urandom;
		if (pick < 13)
			return 32'd0 - $urandom_range(0, cnt_max);
		return $urandom_range(0, cnt_max);
	endfunction

	// One run: a start followed by ticks with realistic sensor stretches and a late marker.
	task random_run(input int ms_max, input int cnt_max, input int len);
		int marker_from, off_run, lost_run, pick;
		logic [1:0] cmd;
		logic fol, onl, lst, mark;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			gen_now = $urandom;
		else if (pick == 1)
			gen_now = 32'hFFFF_FFFF - $urandom_range(0, 200);
		if ($urandom_range(0, 7) == 0)
			put(CMD_START, gen_now, gen_l, gen_r, 1'b0, 1'($urandom_range(0, 1)), 1'b1,
				1'b0, 1'b0);
		put(CMD_START, gen_now, gen_l, gen_r, 1'b1, 1'($urandom_range(0, 1)), 1'b1,
			1'b0, 1'b0);
		marker_from = $urandom_range(0, len);
		off_run = 0;
		lost_run = 0;
		for (int k = 0; k < len; k++) begin
			gen_now += $urandom_range(0, ms_max);
			gen_l += wheel_step(cnt_max);
			gen_r += wheel_step(cnt_max);
			pick = $urandom_range(0, 199);
			if (pick < 2)
				cmd = CMD_STOP;
			else if (pick < 4)
				cmd = CMD_UNUSED;
			else if (pick < 5)
				cmd = CMD_START;
			else
				cmd = CMD_TICK;
			fol = ($urandom_range(0, 59) != 0);
			if (off_run != 0)
				off_run--;
			else if ($urandom_range(0, 24) == 0)
				off_run = $urandom_range(1, 6);
			onl = (off_run == 0);
			if (lost_run != 0)
				lost_run--;
			else if ($urandom_range(0, 19) == 0)
				lost_run = $urandom_range(1, 6);
			lst = (lost_run != 0);
			if (k >= marker_from)
				mark = ($urandom_range(0, 6) != 0);
			else
				mark = ($urandom_range(0, 29) == 0);
			put(cmd, gen_now, gen_l, gen_r, 1'($urandom_range(0, 1)), fol, onl, lst, mark);
		end
	endtask

	initial begin
		int ms_knob[7];
		int cnt_knob[7];
		int ms_max, cnt_max, goal;
		ms_knob = '{5, 20, 1, 100, 10, 3, 50};
		cnt_knob = '{500, 5000, 10, 100000, 2000, 40, 20000};

		// Supervisor copy and registers as they come out of reset.
		run_ph = RS_IDLE;
		fl = '0;
		t_start = '0;
		t_elapsed = '0;
		enc_left = '0;
		enc_right = '0;
		t_marker = '0;
		t_lost = '0;
		t_offline = '0;
		odo = '0;
		odo_at_marker = '0;
		odo_brake = '0;
		motor_stop_due = 1'b0;
		cfg_scale = 24'd65536;
		cfg_approach = '0;
		cfg_arm = '0;
		cfg_post = 24'd230000;
		cfg_lap = 32'd60000;
		cfg_offline = 16'd500;
		cfg_lost = 16'd500;
		cfg_debounce = 16'd20;
		gen_now = 32'd100000;
		gen_l = '0;
		gen_r = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Commands while idle, the unused code and a rejected start.
		put(CMD_TICK, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_STOP, 32'd5, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_UNUSED, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
		put(CMD_START, 32'd100, 32'd0, 32'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		// Start with both chassis flags set, at encoder extremes, just before the time wraps.
		gen_l = 32'h7FFF_FFFF;
		gen_r = 32'h8000_0000;
		put(CMD_START, 32'hFFFF_FFF0, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		// Net backward motion leaves the distance alone.
		gen_l += 32'd1000;
		gen_r -= 32'd3000;
		put(CMD_TICK, 32'hFFFF_FFF8, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		// Time wraps; offline, line loss and marker all begin, then all clear.
		gen_l += 32'd500;
		gen_r += 32'd600;
		put(CMD_TICK, 32'h0000_0004, gen_l, gen_r, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
		put(CMD_TICK, 32'h0000_0010, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		// Marker held through the debounce time starts braking.
		put(CMD_TICK, 32'h0000_0014, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
		put(CMD_TICK, 32'h0000_0020, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
		put(CMD_TICK, 32'h0000_0028, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
		// Largest forward step covers the braking distance; the next tick is ignored.
		gen_l += 32'h7FFF_FFFF;
		gen_r += 32'h7FFF_FFFF;
		put(CMD_TICK, 32'h0000_0030, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_TICK, 32'h0000_0031, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		// Chassis leaves line-follow mode.
		put(CMD_START, 32'd1000, gen_l, gen_r, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
		put(CMD_TICK, 32'd1001, gen_l, gen_r, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
		// Sensor offline for the whole timeout.
		put(CMD_START, 32'd2000, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_TICK, 32'd2001, gen_l, gen_r, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		put(CMD_TICK, 32'd2501, gen_l, gen_r, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
		// Line lost for the whole timeout.
		put(CMD_START, 32'd3000, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_TICK, 32'd3001, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
		put(CMD_TICK, 32'd3501, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
		// Unused code and a restart mid-run, then the lap limit.
		put(CMD_START, 32'd4000, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_UNUSED, 32'd4050, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_START, 32'd4100, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_TICK, 32'd64100, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
		// User stop.
		put(CMD_START, 32'd70000, gen_l, gen_r, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
		put(CMD_STOP, 32'd70010, gen_l, gen_r, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);

		// Random runs: defaults first, then all registers at maximum, all at zero, then mixes.
		for (int p = 0; p < 10; p++) begin
			if (p == 1) begin
				write_reg(REG_DISTANCE_SCALE, 32'h00FF_FFFF);
				write_reg(REG_APPROACH_DIST, 32'h00FF_FFFF);
				write_reg(REG_ARM_DIST, 32'h00FF_FFFF);
				write_reg(REG_POST_MARKER, 32'h00FF_FFFF);
				write_reg(REG_LAP_TIMEOUT, 32'hFFFF_FFFF);
				write_reg(REG_OFFLINE_TMO, 32'h0000_FFFF);
				write_reg(REG_LINE_LOSS_TMO, 32'h0000_FFFF);
				write_reg(REG_MARKER_DEB, 32'h0000_FFFF);
				ms_max = 8000;
				cnt_max = 200000;
			end else if (p == 2) begin
				for (int i = 0; i < 8; i++)
					write_reg(reg_idx_t'(i), '0);
				ms_max = 10;
				cnt_max = 1000;
			end else if (p >= 3) begin
				ms_max = ms_knob[p-3];
				cnt_max = cnt_knob[p-3];
				random_config(ms_max, cnt_max);
			end else begin
				ms_max = 10;
				cnt_max = 4000;
			end
			goal = items_queued + ((p == 2) ? 40 : 100);
			while (items_queued < goal) begin
				// A short burst of arbitrary words between runs.
				if ($urandom_range(0, 5) == 0) begin
					repeat ($urandom_range(3, 10))
						put(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
				end
				random_run(ms_max, cnt_max, $urandom_range(4, 40));
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
design/rsof_pkg.sv
design/run_supervisor_odometry_fsm_unit.sv
tb/run_supervisor_odometry_fsm_unit_tb.sv
